>>> hdl/dhts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhts_pkg
// Shared types and codes for the double-hash record table.
// ----------------------------------------------------------------------------
package dhts_pkg;

  localparam int KEY_W    = 31;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 64;

  localparam logic [2:0] SECOND_HASH_BASE = 3'd7;
  localparam logic [3:0] MOD7_DIVISOR     = 4'd7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } rec_t;

endpackage
`default_nettype wire

>>> hdl/double_hash_table_insert_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table_insert_search
// Insert/search record table with double hashing and linear probing.
// ----------------------------------------------------------------------------
// One item at a time. After an item is taken the key goes through a remainder
// unit (reciprocal multiply then subtract), then the record store is probed at
// one read per cycle with registered read data, then the result is loaded into
// the output register once that register is free. An item reads p records
// (1 to records + 1); the next item can be taken once its result is loaded,
// and the probe walk over the single read port of the record store takes most
// of the time per item. After reset a clearing pass writes every record once,
// NUM_BUCKETS * RECORDS_PER_BUCKET records (32 by default), before the first
// item is taken. A new item is taken while a result still waits on the output.
module double_hash_table_insert_search
  import dhts_pkg::*;
#(
  parameter int NUM_BUCKETS        = 16,
  parameter int RECORDS_PER_BUCKET = 2,
  localparam int NR    = NUM_BUCKETS * RECORDS_PER_BUCKET,
  localparam int IDX_W = $clog2(NR),
  localparam int CNT_W = $clog2(NR + 2),
  localparam int OUT_W = ((IDX_W + CNT_W + DATA_W + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [IN_W-1:0]     s_tdata,  // key_in, data_in
  input  wire logic                s_tuser,  // cmd
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_W-1:0]         m_tdata,  // record_index, probe_count, data_out
  output logic [STATUS_W-1:0]      m_tuser   // status
);

  localparam int BKT_W = $clog2(NUM_BUCKETS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [CNT_W-1:0] LAST_PROBE = CNT_W'(NR + 1);
  localparam logic [IDX_W-1:0] LAST_REC   = IDX_W'(NR - 1);

  logic [2:0]           state;
  logic [IDX_W-1:0]     clr_addr;
  logic                 op_cmd;
  logic [KEY_W-1:0]     op_key;
  logic [DATA_W-1:0]    op_data;
  logic [IDX_W-1:0]     pos;
  logic [IDX_W-1:0]     rd_pos;
  logic                 rd_vld;
  logic [CNT_W-1:0]     issued;

  logic [STATUS_W-1:0]  res_status;
  logic [IDX_W-1:0]     res_index;
  logic [CNT_W-1:0]     res_count;
  logic [DATA_W-1:0]    res_data;

  logic [IDX_W-1:0]     out_index;
  logic [CNT_W-1:0]     out_count;
  logic [DATA_W-1:0]    out_data;

  logic                 in_take;
  logic                 hash_done;
  logic [BKT_W-1:0]     rem_bkt;
  logic [2:0]           rem7;
  logic [IDX_W-1:0]     first_pos;
  logic [IDX_W-1:0]     second_pos;

  logic                 mem_wr_en;
  logic [IDX_W-1:0]     mem_wr_addr;
  rec_t                 mem_wr_data;
  rec_t                 rd_data;

  logic                 hit;
  logic                 last;
  logic [IDX_W-1:0]     pos_step;

  assign s_tready = (state == S_IDLE);
  assign in_take  = s_tvalid && s_tready;

  dhts_hash #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BKT_W       (BKT_W)
  ) u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (in_take),
    .key     (s_tdata[KEY_W-1:0]),
    .done    (hash_done),
    .rem_bkt (rem_bkt),
    .rem7    (rem7)
  );

  assign first_pos  = IDX_W'(rem_bkt * RECORDS_PER_BUCKET);
  assign second_pos = IDX_W'((SECOND_HASH_BASE - rem7) * RECORDS_PER_BUCKET);
  assign pos_step   = (pos == LAST_REC) ? '0 : pos + 1'b1;

  always_comb begin
    if (op_cmd == CMD_INSERT) begin
      hit = rd_vld && !rd_data.valid;
    end else begin
      hit = rd_vld && rd_data.valid && (rd_data.key == op_key);
    end
    last = rd_vld && (issued == LAST_PROBE);
  end

  always_comb begin
    if (state == S_CLEAR) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = clr_addr;
      mem_wr_data = '0;
    end else begin
      mem_wr_en   = (state == S_PROBE) && hit && (op_cmd == CMD_INSERT);
      mem_wr_addr = rd_pos;
      mem_wr_data = '{valid: 1'b1, key: op_key, data: op_data};
    end
  end

  dhts_mem #(
    .DEPTH  (NR),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
      rd_vld   <= 1'b0;
      issued   <= '0;
    end else begin
      if (state == S_FIN && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_REC) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state  <= S_PROBE;
            issued <= '0;
            rd_vld <= 1'b0;
          end
        end
        S_PROBE: begin
          if (hit || last) begin
            state  <= S_FIN;
            rd_vld <= 1'b0;
          end else begin
            issued <= issued + 1'b1;
            rd_vld <= 1'b1;
          end
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_cmd  <= s_tuser;
      op_key  <= s_tdata[KEY_W-1:0];
      op_data <= s_tdata[KEY_W+DATA_W-1:KEY_W];
    end
    if (state == S_HASH && hash_done) begin
      pos <= first_pos;
    end else if (state == S_PROBE) begin
      rd_pos <= pos;
      pos    <= (issued == '0) ? second_pos : pos_step;
    end
    if (state == S_PROBE && (hit || last)) begin
      res_count <= issued;
      if (hit) begin
        res_status <= (op_cmd == CMD_INSERT) ? ST_INSERTED : ST_FOUND;
        res_index  <= rd_pos;
        res_data   <= (op_cmd == CMD_SEARCH) ? rd_data.data : '0;
      end else begin
        res_status <= (op_cmd == CMD_INSERT) ? ST_FULL : ST_MISSING;
        res_index  <= '0;
        res_data   <= '0;
      end
    end
    if (state == S_FIN && (!m_tvalid || m_tready)) begin
      m_tuser   <= res_status;
      out_index <= res_index;
      out_count <= res_count;
      out_data  <= res_data;
    end
  end

  assign m_tdata = OUT_W'({out_data, out_count, out_index});

  a_probe_write_only_on_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && mem_wr_en) |-> (op_cmd == CMD_INSERT && !rd_data.valid))
    else $error("probe write to an occupied record");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (issued <= LAST_PROBE))
    else $error("probe count past the last position");

  a_result_after_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_FIN))
    else $error("result shown without a finished item");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count != '0))
    else $error("result with zero probes");

  a_found_has_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && hit && op_cmd == CMD_SEARCH) |-> rd_data.valid)
    else $error("search hit on an empty record");

endmodule
`default_nettype wire

>>> hdl/dhts_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhts_hash
// Remainder unit: key mod NUM_BUCKETS and key mod 7 by reciprocal multiply;
// the key, the quotient and then the remainder are registered in turn.
// ----------------------------------------------------------------------------
module dhts_hash
  import dhts_pkg::*;
#(
  parameter int NUM_BUCKETS = 16,
  parameter int BKT_W       = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  output logic                  done,
  output logic [BKT_W-1:0]      rem_bkt,
  output logic [2:0]            rem7
);

  localparam int PROD_W  = 2 * KEY_W + 1;
  localparam int BKT_SH  = KEY_W + $clog2(NUM_BUCKETS);
  localparam int MOD7_SH = KEY_W + 3;
  localparam longint unsigned BKT_RECIP =
    ((64'd1 << BKT_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam longint unsigned MOD7_RECIP =
    ((64'd1 << MOD7_SH) + 64'(MOD7_DIVISOR) - 64'd1) / 64'(MOD7_DIVISOR);
  localparam logic [KEY_W:0]   BKT_MUL  = (KEY_W+1)'(BKT_RECIP);
  localparam logic [KEY_W:0]   MOD7_MUL = (KEY_W+1)'(MOD7_RECIP);
  localparam logic [KEY_W-1:0] NB_K     = KEY_W'(NUM_BUCKETS);
  localparam logic [KEY_W-1:0] D7_K     = KEY_W'(MOD7_DIVISOR);

  logic              stage1;
  logic              stage2;
  logic [KEY_W-1:0]  key_q;
  logic [PROD_W-1:0] bkt_prod;
  logic [PROD_W-1:0] mod7_prod;
  logic [KEY_W-1:0]  bkt_quot;
  logic [KEY_W-1:0]  mod7_quot;
  logic [KEY_W-1:0]  bkt_rem;
  logic [KEY_W-1:0]  mod7_rem;

  assign bkt_prod  = PROD_W'(key_q) * PROD_W'(BKT_MUL);
  assign mod7_prod = PROD_W'(key_q) * PROD_W'(MOD7_MUL);
  assign bkt_rem   = key_q - bkt_quot * NB_K;
  assign mod7_rem  = key_q - mod7_quot * D7_K;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    if (stage1) begin
      bkt_quot  <= KEY_W'(bkt_prod >> BKT_SH);
      mod7_quot <= KEY_W'(mod7_prod >> MOD7_SH);
    end
    if (stage2) begin
      rem_bkt <= bkt_rem[BKT_W-1:0];
      rem7    <= mod7_rem[2:0];
    end
  end

endmodule
`default_nettype wire

>>> hdl/dhts_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhts_mem
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dhts_mem
  import dhts_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire rec_t              wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output rec_t                   rd_data
);

  rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
